// File: rtl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// Mutex table package
// Sizes, request classes, status codes and the request record shared by the
// front and back parts of the lock manager.
// ----------------------------------------------------------------------------
`default_nettype none
package mtf_pkg;

	localparam int NUM_LOCKS      = 16;
	localparam int WAIT_DEPTH     = 8;
	localparam int REQUESTER_BITS = 8;

	localparam int LOCK_W  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
	localparam int HEAD_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int CNT_W   = $clog2(WAIT_DEPTH + 1);
	localparam int WSTORE_D = NUM_LOCKS * WAIT_DEPTH;
	localparam int WADDR_W = (WSTORE_D > 1) ? $clog2(WSTORE_D) : 1;

	// Field widths of the ports.
	localparam int KIND_W   = 2;
	localparam int INDEX_W  = 4;
	localparam int REQ_W    = 8;
	localparam int STATUS_W = 2;

	// Request kinds as they arrive on the port.
	localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_QUEUED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd2;

	// Request class decided by the front part.
	typedef enum logic [1:0] {
		CL_CREATE,
		CL_ACQUIRE,
		CL_RELEASE,
		CL_BAD
	} req_class_t;

	typedef struct packed {
		req_class_t                cls;
		logic [INDEX_W-1:0]        idx;
		logic                      idx_ok;
		logic [REQUESTER_BITS-1:0] who;
	} req_t;

endpackage
`default_nettype wire

// File: rtl/mtf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mtf_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                     wdata,
	input  wire logic                             re,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic      [W-1:0]                     rdata
);

	logic [W-1:0] mem [D];

	// Read data registered; a read of the address being written returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/mtf_front.sv
// ----------------------------------------------------------------------------
// Mutex table front part
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module mtf_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [mtf_pkg::KIND_W-1:0]   kind,
	input  wire logic [mtf_pkg::INDEX_W-1:0]  lock_index,
	input  wire logic [mtf_pkg::REQ_W-1:0]    requester,
	output logic                              q_valid,
	output mtf_pkg::req_t                     q_req,
	input  wire logic                         q_pop
);

	mtf_pkg::req_t req_in;
	mtf_pkg::req_t fifo_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;

	// Classify the incoming request.
	always_comb begin
		unique case (kind)
			mtf_pkg::KIND_CREATE:  req_in.cls = mtf_pkg::CL_CREATE;
			mtf_pkg::KIND_ACQUIRE: req_in.cls = mtf_pkg::CL_ACQUIRE;
			mtf_pkg::KIND_RELEASE: req_in.cls = mtf_pkg::CL_RELEASE;
			default:               req_in.cls = mtf_pkg::CL_BAD;
		endcase
		req_in.idx    = lock_index;
		req_in.idx_ok = (32'(lock_index) < mtf_pkg::NUM_LOCKS);
		req_in.who    = mtf_pkg::REQUESTER_BITS'(requester);
	end

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_req   = fifo_q[rd_ptr_q];

	// Queue payload.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= req_in;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/mtf_back.sv
// ----------------------------------------------------------------------------
// Mutex table back part
// Executes a request by first reading the waiter store, then updating the
// lock entry and registering the result.
// ----------------------------------------------------------------------------
`default_nettype none
module mtf_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire mtf_pkg::req_t                 q_req,
	output logic                               q_pop,
	output logic                               done,
	output logic [mtf_pkg::STATUS_W-1:0]       status,
	output logic [mtf_pkg::INDEX_W-1:0]        new_lock,
	output logic                               handoff_valid,
	output logic [mtf_pkg::REQ_W-1:0]          handoff_process
);

	localparam int LW = mtf_pkg::LOCK_W;
	localparam int HW = mtf_pkg::HEAD_W;
	localparam int CW = mtf_pkg::CNT_W;
	localparam int RB = mtf_pkg::REQUESTER_BITS;
	localparam int AW = mtf_pkg::WADDR_W;

	logic [mtf_pkg::NUM_LOCKS-1:0] in_use_q;
	logic [mtf_pkg::NUM_LOCKS-1:0] held_q;
	logic [RB-1:0]                 owner_q [mtf_pkg::NUM_LOCKS];
	logic [HW-1:0]                 head_q  [mtf_pkg::NUM_LOCKS];
	logic [CW-1:0]                 count_q [mtf_pkg::NUM_LOCKS];

	logic          vld_s1;
	mtf_pkg::req_t req_s1;

	logic [LW-1:0] pop_sel;
	logic [AW-1:0] rd_addr;
	logic [RB-1:0] rd_data;

	logic [LW-1:0] sel;
	logic [HW-1:0] cur_head;
	logic [CW-1:0] cur_count;
	logic [HW:0]   tail_sum;
	logic [HW-1:0] tail_slot;
	logic [HW-1:0] head_next;
	logic          entry_ok;
	logic          free_found;
	logic [LW-1:0] free_sel;

	logic                          ram_we;
	logic [AW-1:0]                 wr_addr;
	logic [mtf_pkg::STATUS_W-1:0]  st_d;
	logic [mtf_pkg::INDEX_W-1:0]   nl_d;
	logic                          hv_d;
	logic [RB-1:0]                 hp_d;

	typedef enum logic [2:0] {
		UP_NONE,
		UP_CREATE,
		UP_GRANT,
		UP_ENQUEUE,
		UP_HANDOFF,
		UP_FREE
	} upd_t;
	upd_t upd;

	// Take a request whenever the execute stage is empty.
	assign q_pop   = q_valid && !vld_s1;
	assign pop_sel = LW'(q_req.idx);
	assign rd_addr = AW'(32'(pop_sel) * mtf_pkg::WAIT_DEPTH + 32'(head_q[pop_sel]));

	mtf_ram #(.W(RB), .D(mtf_pkg::WSTORE_D)) u_wstore (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (req_s1.who),
		.re    (q_pop),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Stage register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_s1 <= q_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= q_pop;
		end
	end

	// Lowest free entry for a create.
	always_comb begin
		free_found = 1'b0;
		free_sel   = '0;
		for (int i = mtf_pkg::NUM_LOCKS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_sel   = LW'(i);
			end
		end
	end

	// Entry fields and queue slot arithmetic.
	assign sel       = LW'(req_s1.idx);
	assign cur_head  = head_q[sel];
	assign cur_count = count_q[sel];
	assign entry_ok  = req_s1.idx_ok && in_use_q[sel];
	assign tail_sum  = (HW + 1)'(cur_head) + (HW + 1)'(cur_count);
	assign tail_slot = (32'(tail_sum) >= mtf_pkg::WAIT_DEPTH)
		? HW'(32'(tail_sum) - mtf_pkg::WAIT_DEPTH) : HW'(tail_sum);
	assign head_next = (32'(cur_head) == mtf_pkg::WAIT_DEPTH - 1) ? '0 : cur_head + HW'(1);
	assign wr_addr   = AW'(32'(sel) * mtf_pkg::WAIT_DEPTH + 32'(tail_slot));

	// Decide the outcome of the request in the execute stage.
	always_comb begin
		upd  = UP_NONE;
		st_d = mtf_pkg::ST_ERROR;
		nl_d = '0;
		hv_d = 1'b0;
		hp_d = '0;
		unique case (req_s1.cls)
			mtf_pkg::CL_CREATE: begin
				if (free_found) begin
					upd  = UP_CREATE;
					st_d = mtf_pkg::ST_OK;
					nl_d = mtf_pkg::INDEX_W'(free_sel);
				end
			end
			mtf_pkg::CL_ACQUIRE: begin
				if (entry_ok) begin
					if (!held_q[sel]) begin
						upd  = UP_GRANT;
						st_d = mtf_pkg::ST_OK;
					end else if (owner_q[sel] != req_s1.who
						&& cur_count != CW'(mtf_pkg::WAIT_DEPTH)) begin
						upd  = UP_ENQUEUE;
						st_d = mtf_pkg::ST_QUEUED;
					end
				end
			end
			mtf_pkg::CL_RELEASE: begin
				if (entry_ok && held_q[sel] && owner_q[sel] == req_s1.who) begin
					st_d = mtf_pkg::ST_OK;
					if (cur_count != '0) begin
						upd  = UP_HANDOFF;
						hv_d = 1'b1;
						hp_d = rd_data;
					end else begin
						upd = UP_FREE;
					end
				end
			end
			default: begin
				upd = UP_NONE;
			end
		endcase
	end

	assign ram_we = vld_s1 && (upd == UP_ENQUEUE);

	// Lock table update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			held_q   <= '0;
			for (int i = 0; i < mtf_pkg::NUM_LOCKS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (vld_s1) begin
			unique case (upd)
				UP_CREATE: begin
					in_use_q[free_sel] <= 1'b1;
					held_q[free_sel]   <= 1'b0;
					head_q[free_sel]   <= '0;
					count_q[free_sel]  <= '0;
				end
				UP_GRANT: begin
					held_q[sel] <= 1'b1;
				end
				UP_ENQUEUE: begin
					count_q[sel] <= cur_count + CW'(1);
				end
				UP_HANDOFF: begin
					head_q[sel]  <= head_next;
					count_q[sel] <= cur_count - CW'(1);
				end
				UP_FREE: begin
					held_q[sel] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Owner store; read only while its lock is held.
	always_ff @(posedge clk) begin
		if (vld_s1 && upd == UP_GRANT) begin
			owner_q[sel] <= req_s1.who;
		end else if (vld_s1 && upd == UP_HANDOFF) begin
			owner_q[sel] <= rd_data;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			status          <= st_d;
			new_lock        <= nl_d;
			handoff_valid   <= hv_d;
			handoff_process <= mtf_pkg::REQ_W'(hp_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s1;
		end
	end

endmodule
`default_nettype wire

// File: rtl/mutex_table_with_fifo_handoff.sv
// ----------------------------------------------------------------------------
// Mutex table with FIFO handoff
// Lock manager with per-lock owner and waiter queue; a release passes the
// lock to the oldest waiter.
//
// Channel   Signals                                     Transfer
// request   start, busy, kind, lock_index, requester    start && !busy
// result    done, status, new_lock, handoff_valid,      done (one cycle)
//           handoff_process
//
// A request is popped from the queue while the waiter store RAM is read,
// then updates the lock entry in the execute stage, and its result is
// registered. The back part pops no new request while one is in the single
// execute stage. A two-entry queue between front and back raises busy only
// when full. Reset clears all lock marks and queue counters at once.
// ----------------------------------------------------------------------------
`default_nettype none
module mutex_table_with_fifo_handoff (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [mtf_pkg::KIND_W-1:0]    kind,
	input  wire logic [mtf_pkg::INDEX_W-1:0]   lock_index,
	input  wire logic [mtf_pkg::REQ_W-1:0]     requester,
	output logic                               done,
	output logic [mtf_pkg::STATUS_W-1:0]       status,
	output logic [mtf_pkg::INDEX_W-1:0]        new_lock,
	output logic                               handoff_valid,
	output logic [mtf_pkg::REQ_W-1:0]          handoff_process
);

	logic          q_valid;
	logic          q_pop;
	mtf_pkg::req_t q_req;

	mtf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.lock_index (lock_index),
		.requester  (requester),
		.q_valid    (q_valid),
		.q_req      (q_req),
		.q_pop      (q_pop)
	);

	mtf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_req           (q_req),
		.q_pop           (q_pop),
		.done            (done),
		.status          (status),
		.new_lock        (new_lock),
		.handoff_valid   (handoff_valid),
		.handoff_process (handoff_process)
	);

	// A popped request always gives a result, after the execute stage and the result register.
	a_done_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> ##1 done)
		else $error("result did not follow a popped request");

	// Results never come back to back.
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// A handoff is always a successful release.
	a_handoff_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && handoff_valid) |-> (status == mtf_pkg::ST_OK && new_lock == '0))
		else $error("handoff reported with a bad status");

endmodule
`default_nettype wire
